/* src/trust_table_ewma_lru_defines.svh */
// Assertion macros shared by the trust table RTL.
`ifndef TRUST_TABLE_EWMA_LRU_DEFINES_SVH
`define TRUST_TABLE_EWMA_LRU_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on the rising edge, muted while reset is high.
`define TTEL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("trust table check failed");
// Check a property on the rising edge, reset cycles included.
`define TTEL_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("trust table check failed");
`else
`define TTEL_ASSERT(lbl, clk, rst, prop)
`define TTEL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* src/ttel_pkg.sv */
package ttel_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int CMD_W   = 2;
   localparam int KEY_W   = 64;
   localparam int TRUST_W = 17;
   localparam int STAMP_W = 32;
   localparam int COUNT_W = 5;

   // blend arithmetic: sum = 7*t + 3*q + 5 fits in SUM_W bits,
   // divide by ten as (sum * RECIP) >> RECIP_SHIFT, exact for SUM_W <= 20
   localparam int SUM_W       = 20;
   localparam int RECIP_W     = 21;
   localparam int RECIP_SHIFT = 24;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = 21'd1677722;

   // Q1.16 trust constants
   localparam logic [TRUST_W-1:0] TRUST_ONE     = 17'd65536;
   localparam logic [TRUST_W-1:0] TRUST_NEUTRAL = 17'd32768;
   localparam logic [TRUST_W-1:0] FAIL_PENALTY  = 17'd9830;

   typedef enum logic [CMD_W-1:0] {
      CMD_SUCCESS = 2'd0,
      CMD_FAILURE = 2'd1,
      CMD_GET     = 2'd2,
      CMD_DECAY   = 2'd3
   } ttel_op_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic scan;
      logic decide;
      logic load;
      logic mul;
      logic write;
      logic resp_load;
   } ttel_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
   } ttel_sts_type;

endpackage

/* src/ttel_ctrl.sv */
`include "trust_table_ewma_lru_defines.svh"

module ttel_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ttel_pkg::ttel_cmd_type cmd,
   input  ttel_pkg::ttel_sts_type sts
);
   import ttel_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_LOAD,
      ST_MUL,
      ST_WRITE,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // sequence one beat through scan, decide, arithmetic and response
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.resp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `TTEL_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> state_ff == ST_IDLE && !rsp_valid_ff)
   `TTEL_ASSERT(a_accept_scan, clock, reset, req_valid && req_ready |=> state_ff == ST_SCAN)
   `TTEL_ASSERT(a_resp_wait, clock, reset, state_ff == ST_RESP && rsp_valid_ff && !rsp_ready |=> state_ff == ST_RESP)
   `TTEL_ASSERT(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP)

endmodule

/* src/ttel_dpath.sv */
`include "trust_table_ewma_lru_defines.svh"

module ttel_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  ttel_pkg::ttel_cmd_type          cmd,
   output ttel_pkg::ttel_sts_type          sts,
   input  logic [ttel_pkg::CMD_W-1:0]      req_command,
   input  logic [ttel_pkg::KEY_W-1:0]      req_addr_hi,
   input  logic [ttel_pkg::KEY_W-1:0]      req_addr_lo,
   input  logic [ttel_pkg::TRUST_W-1:0]    req_link_quality,
   input  logic [ttel_pkg::TRUST_W-1:0]    req_decay_step,
   input  logic [ttel_pkg::STAMP_W-1:0]    req_now_time,
   output logic [ttel_pkg::TRUST_W-1:0]    rsp_trust_value,
   output logic                            rsp_was_present,
   output logic [ttel_pkg::COUNT_W-1:0]    rsp_entry_count
);
   import ttel_pkg::*;

   // table storage
   logic [KEY_W-1:0]   key_hi_mem_ff [TABLE_DEPTH];
   logic [KEY_W-1:0]   key_lo_mem_ff [TABLE_DEPTH];
   logic [TRUST_W-1:0] trust_mem_ff  [TABLE_DEPTH];
   logic [STAMP_W-1:0] stamp_mem_ff  [TABLE_DEPTH];

   logic [KEY_W-1:0]   key_hi_rd_ff, key_lo_rd_ff;
   logic [TRUST_W-1:0] trust_rd_ff;
   logic [STAMP_W-1:0] stamp_rd_ff;
   logic [IDX_W-1:0]   rd_addr;

   // latched request
   ttel_op_type        op_ff;
   logic [KEY_W-1:0]   key_hi_ff, key_lo_ff;
   logic [TRUST_W-1:0] lq_ff, ds_ff;
   logic [STAMP_W-1:0] now_ff;

   // scan state
   logic [CNT_W-1:0]   iss_ff;
   logic [IDX_W-1:0]   pidx_ff;
   logic               pend_ff;
   logic               hit_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic [STAMP_W-1:0] min_stamp_ff;
   logic [IDX_W-1:0]   min_idx_ff;
   logic               key_match;
   logic               issue;

   // target selection
   logic [CNT_W-1:0]   occ_ff;
   logic [IDX_W-1:0]   tgt_ff, tgt_in;
   logic               tvalid_ff, tvalid_in;
   logic               alloc_ff, alloc_in;
   logic               grow;
   logic               is_upd;

   // arithmetic
   logic [TRUST_W-1:0] base_ff, base_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [PROD_W-1:0]  prod;
   logic [TRUST_W-1:0] quo_ff;
   logic [TRUST_W-1:0] t_new;
   logic [TRUST_W-1:0] res_ff;
   logic               we_trust, we_stamp, we_key;

   // response register
   logic [TRUST_W-1:0] rsp_trust_ff;
   logic               rsp_present_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   assign is_upd    = (op_ff == CMD_SUCCESS) || (op_ff == CMD_FAILURE);
   assign issue     = (iss_ff < occ_ff);
   assign key_match = pend_ff && (key_hi_rd_ff == key_hi_ff) && (key_lo_rd_ff == key_lo_ff);
   assign sts.scan_done = hit_ff || (!pend_ff && !issue);

   // pick the entry to touch: hit, next free slot, or oldest stamp
   always_comb begin
      tgt_in    = hit_idx_ff;
      tvalid_in = 1'b1;
      alloc_in  = 1'b0;
      grow      = 1'b0;
      if (!hit_ff) begin
         if (is_upd) begin
            alloc_in = 1'b1;
            if (occ_ff < CNT_W'(TABLE_DEPTH)) begin
               tgt_in = occ_ff[IDX_W-1:0];
               grow   = 1'b1;
            end else begin
               tgt_in = min_idx_ff;
            end
         end else begin
            tvalid_in = 1'b0;
         end
      end
   end

   assign rd_addr = cmd.decide ? tgt_in : iss_ff[IDX_W-1:0];

   // read all stores at one address, data registered
   always_ff @(posedge clock) begin
      key_hi_rd_ff <= key_hi_mem_ff[rd_addr];
      key_lo_rd_ff <= key_lo_mem_ff[rd_addr];
      trust_rd_ff  <= trust_mem_ff[rd_addr];
      stamp_rd_ff  <= stamp_mem_ff[rd_addr];
   end

   // write back the touched entry
   assign we_trust = cmd.write && tvalid_ff && (op_ff != CMD_GET);
   assign we_stamp = cmd.write && tvalid_ff && is_upd;
   assign we_key   = cmd.write && tvalid_ff && alloc_ff;

   always_ff @(posedge clock) begin
      if (we_trust) begin
         trust_mem_ff[tgt_ff] <= t_new;
      end
      if (we_stamp) begin
         stamp_mem_ff[tgt_ff] <= now_ff;
      end
      if (we_key) begin
         key_hi_mem_ff[tgt_ff] <= key_hi_ff;
         key_lo_mem_ff[tgt_ff] <= key_lo_ff;
      end
   end

   // control registers of scan and allocation
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff    <= '0;
         pend_ff   <= 1'b0;
         hit_ff    <= 1'b0;
         occ_ff    <= '0;
         tvalid_ff <= 1'b0;
         alloc_ff  <= 1'b0;
      end else begin
         if (cmd.start) begin
            iss_ff  <= '0;
            pend_ff <= 1'b0;
            hit_ff  <= 1'b0;
         end else if (cmd.scan && !hit_ff) begin
            pend_ff <= issue;
            if (issue) begin
               iss_ff <= iss_ff + CNT_W'(1);
            end
            if (key_match) begin
               hit_ff <= 1'b1;
            end
         end
         if (cmd.decide) begin
            tvalid_ff <= tvalid_in;
            alloc_ff  <= alloc_in;
            if (grow) begin
               occ_ff <= occ_ff + CNT_W'(1);
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff     <= ttel_op_type'(req_command);
         key_hi_ff <= req_addr_hi;
         key_lo_ff <= req_addr_lo;
         lq_ff     <= req_link_quality;
         ds_ff     <= req_decay_step;
         now_ff    <= req_now_time;
      end
      if (cmd.scan && !hit_ff) begin
         pidx_ff <= iss_ff[IDX_W-1:0];
         if (key_match) begin
            hit_idx_ff <= pidx_ff;
         end
         // track oldest stamp, strict compare keeps the lowest index on a tie
         if (pend_ff && ((pidx_ff == '0) || (stamp_rd_ff < min_stamp_ff))) begin
            min_stamp_ff <= stamp_rd_ff;
            min_idx_ff   <= pidx_ff;
         end
      end
      if (cmd.decide) begin
         tgt_ff <= tgt_in;
      end
      if (cmd.load) begin
         base_ff <= base_in;
         sum_ff  <= sum_in;
      end
      if (cmd.mul) begin
         quo_ff <= prod[RECIP_SHIFT +: TRUST_W];
      end
      if (cmd.write) begin
         res_ff <= t_new;
      end
      if (cmd.resp_load) begin
         rsp_trust_ff   <= res_ff;
         rsp_present_ff <= hit_ff;
         rsp_count_ff   <= COUNT_W'(occ_ff);
      end
   end

   // blend sum 7*t + 3*q + 5
   assign base_in = alloc_ff ? TRUST_NEUTRAL : trust_rd_ff;
   assign sum_in  = SUM_W'(base_in) * SUM_W'(7) + SUM_W'(lq_ff) * SUM_W'(3) + SUM_W'(5);

   // divide by ten through the reciprocal
   assign prod = PROD_W'(sum_ff) * PROD_W'(RECIP);

   // apply the command and clamp
   always_comb begin
      t_new = TRUST_NEUTRAL;
      if (tvalid_ff) begin
         case (op_ff)
            CMD_SUCCESS: t_new = (quo_ff > TRUST_ONE) ? TRUST_ONE : quo_ff;
            CMD_FAILURE: t_new = (base_ff > FAIL_PENALTY) ? (base_ff - FAIL_PENALTY) : '0;
            CMD_DECAY:   t_new = (base_ff > ds_ff) ? (base_ff - ds_ff) : '0;
            CMD_GET:     t_new = base_ff;
            default:     t_new = base_ff;
         endcase
      end
   end

   assign rsp_trust_value = rsp_trust_ff;
   assign rsp_was_present = rsp_present_ff;
   assign rsp_entry_count = rsp_count_ff;

   `TTEL_ASSERT(a_occ_bound, clock, reset, occ_ff <= CNT_W'(TABLE_DEPTH))
   `TTEL_ASSERT(a_occ_step, clock, reset, !$past(reset) && occ_ff != $past(occ_ff) |-> occ_ff == $past(occ_ff) + CNT_W'(1))
   `TTEL_ASSERT(a_trust_range, clock, reset, we_trust |-> t_new <= TRUST_ONE)

endmodule

/* src/trust_table_ewma_lru.sv */
// A miss scans every occupied entry; a hit ends the key scan early.
// Throughput: one request at a time; the key scan reads one entry a cycle
// from the single read port of the table stores, then the update runs
// through the decide, load, multiply, write and response states.
// Reset: synchronous, active high; empties the table (count to zero), no clearing pass.
module trust_table_ewma_lru (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ttel_pkg::CMD_W-1:0]   req_command,
   input  logic [ttel_pkg::KEY_W-1:0]   req_addr_hi,
   input  logic [ttel_pkg::KEY_W-1:0]   req_addr_lo,
   input  logic [ttel_pkg::TRUST_W-1:0] req_link_quality,
   input  logic [ttel_pkg::TRUST_W-1:0] req_decay_step,
   input  logic [ttel_pkg::STAMP_W-1:0] req_now_time,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ttel_pkg::TRUST_W-1:0] rsp_trust_value,
   output logic                         rsp_was_present,
   output logic [ttel_pkg::COUNT_W-1:0] rsp_entry_count
);
   import ttel_pkg::*;

   ttel_cmd_type cmd;
   ttel_sts_type sts;

   ttel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ttel_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_command      (req_command),
      .req_addr_hi      (req_addr_hi),
      .req_addr_lo      (req_addr_lo),
      .req_link_quality (req_link_quality),
      .req_decay_step   (req_decay_step),
      .req_now_time     (req_now_time),
      .rsp_trust_value  (rsp_trust_value),
      .rsp_was_present  (rsp_was_present),
      .rsp_entry_count  (rsp_entry_count)
   );

endmodule

/* sim/trust_table_ewma_lru_test.sv */
module trust_table_ewma_lru_test;
   import ttel_pkg::*;

   localparam int LIMIT_CYCLES     = 200000;
   localparam int RANDOM_ITEMS     = 900;
   localparam int POOL_SIZE        = 24;
   localparam int SYNC_EVERY       = 150;
   localparam int LONG_HOLD_AT     = 200;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 40;

   typedef struct {
      ttel_op_type        cmd;
      logic [KEY_W-1:0]   hi;
      logic [KEY_W-1:0]   lo;
      logic [TRUST_W-1:0] lq;
      logic [TRUST_W-1:0] ds;
      logic [STAMP_W-1:0] now;
      int unsigned        gap;
      bit                 sync;
   } trust_req_type;

   typedef struct {
      logic [TRUST_W-1:0] trust_value;
      logic               was_present;
      logic [COUNT_W-1:0] entry_count;
   } trust_rsp_type;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_command      = '0;
   logic [KEY_W-1:0]     req_addr_hi      = '0;
   logic [KEY_W-1:0]     req_addr_lo      = '0;
   logic [TRUST_W-1:0]   req_link_quality = '0;
   logic [TRUST_W-1:0]   req_decay_step   = '0;
   logic [STAMP_W-1:0]   req_now_time     = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [TRUST_W-1:0]   rsp_trust_value;
   logic                 rsp_was_present;
   logic [COUNT_W-1:0]   rsp_entry_count;

   trust_req_type pending_reqs[$];
   trust_rsp_type trust_expect[$];
   trust_req_type cur_req;

   // predictor copy of the table
   logic [KEY_W-1:0]   tbl_hi[TABLE_DEPTH];
   logic [KEY_W-1:0]   tbl_lo[TABLE_DEPTH];
   logic [TRUST_W-1:0] tbl_trust[TABLE_DEPTH];
   logic [STAMP_W-1:0] tbl_stamp[TABLE_DEPTH];
   int                 tbl_count = 0;

   logic [KEY_W-1:0] pool_hi[POOL_SIZE];
   logic [KEY_W-1:0] pool_lo[POOL_SIZE];

   int          errors      = 0;
   int          n_req       = 0;
   int          n_rsp       = 0;
   int          n_hit       = 0;
   int          n_alloc     = 0;
   int          n_evict     = 0;
   int          cycle_count = 0;
   int unsigned hold_cycles = 0;
   int unsigned stall_left  = 0;

   trust_table_ewma_lru dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_addr_hi      (req_addr_hi),
      .req_addr_lo      (req_addr_lo),
      .req_link_quality (req_link_quality),
      .req_decay_step   (req_decay_step),
      .req_now_time     (req_now_time),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_trust_value  (rsp_trust_value),
      .rsp_was_present  (rsp_was_present),
      .rsp_entry_count  (rsp_entry_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // idle draw 0..8, with stretches of back-to-back beats
   function automatic int unsigned draw_gap(int n);
      if ((n / 60) % 3 == 2)
         return 0;
      return $urandom_range(0, 8);
   endfunction

   // random Q1.16 value from 0 to hi
   function automatic logic [TRUST_W-1:0] rand_q(int unsigned hi);
      return TRUST_W'($urandom_range(0, hi));
   endfunction

   // look up or allocate, update trust, and queue the expected response
   task automatic apply_trust_update(input trust_req_type r);
      int                 found;
      int                 idx;
      logic [TRUST_W-1:0] t;
      longint unsigned    blend;
      trust_rsp_type      e;
      found = -1;
      for (int i = 0; i < tbl_count; i++)
         if (found < 0 && tbl_hi[i] == r.hi && tbl_lo[i] == r.lo)
            found = i;
      e.was_present = (found >= 0);
      e.trust_value = TRUST_NEUTRAL;
      if (found >= 0)
         n_hit++;
      if (r.cmd == CMD_SUCCESS || r.cmd == CMD_FAILURE) begin
         if (found >= 0) begin
            idx = found;
         end else begin
            // replace the oldest stamp when full, lowest index on a tie
            if (tbl_count >= TABLE_DEPTH) begin
               idx = 0;
               for (int i = 1; i < TABLE_DEPTH; i++)
                  if (tbl_stamp[i] < tbl_stamp[idx])
                     idx = i;
               n_evict++;
            end else begin
               idx = tbl_count;
               tbl_count++;
            end
            tbl_hi[idx]    = r.hi;
            tbl_lo[idx]    = r.lo;
            tbl_trust[idx] = TRUST_NEUTRAL;
            n_alloc++;
         end
         tbl_stamp[idx] = r.now;
         t = tbl_trust[idx];
         if (r.cmd == CMD_SUCCESS) begin
            blend = (7 * longint'(t) + 3 * longint'(r.lq) + 5) / 10;
            t = (blend > TRUST_ONE) ? TRUST_ONE : blend[TRUST_W-1:0];
         end else begin
            t = (t > FAIL_PENALTY) ? t - FAIL_PENALTY : '0;
         end
         tbl_trust[idx] = t;
         e.trust_value  = t;
      end else if (found >= 0) begin
         if (r.cmd == CMD_DECAY)
            tbl_trust[found] = (tbl_trust[found] > r.ds) ? tbl_trust[found] - r.ds : '0;
         e.trust_value = tbl_trust[found];
      end
      e.entry_count = tbl_count[COUNT_W-1:0];
      trust_expect.push_back(e);
   endtask

   task automatic push_req(input ttel_op_type cmd, input int key, input logic [TRUST_W-1:0] lq,
                           input logic [TRUST_W-1:0] ds, input logic [STAMP_W-1:0] now);
      trust_req_type r;
      r.cmd  = cmd;
      r.hi   = pool_hi[key];
      r.lo   = pool_lo[key];
      r.lq   = lq;
      r.ds   = ds;
      r.now  = now;
      r.gap  = draw_gap(pending_reqs.size());
      r.sync = 1'b0;
      pending_reqs.push_back(r);
   endtask

   // driver: offer one request beat at a time from the pending queue
   always @(posedge clock) begin : drive_req
      logic offer;
      if (reset) begin
         req_valid   <= 1'b0;
         hold_cycles = 0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            apply_trust_update(cur_req);
            n_req++;
            offer = 1'b0;
            if (pending_reqs.size() != 0)
               hold_cycles = pending_reqs[0].gap;
         end
         if (!offer && pending_reqs.size() != 0) begin
            if (hold_cycles > 0) begin
               hold_cycles--;
            end else if (!(pending_reqs[0].sync && trust_expect.size() != 0)) begin
               cur_req          = pending_reqs.pop_front();
               offer            = 1'b1;
               req_command      <= cur_req.cmd;
               req_addr_hi      <= cur_req.hi;
               req_addr_lo      <= cur_req.lo;
               req_link_quality <= cur_req.lq;
               req_decay_step   <= cur_req.ds;
               req_now_time     <= cur_req.now;
            end
         end
         req_valid <= offer;
      end
   end

   // monitor: check each response beat, then stall the receiver for a draw or the long hold
   always @(posedge clock) begin : watch_rsp
      trust_rsp_type e;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (trust_expect.size() == 0) begin
               $display("%0t: response beat with nothing expected: trust %0d present %0d count %0d",
                        $time, rsp_trust_value, rsp_was_present, rsp_entry_count);
               errors++;
            end else begin
               e = trust_expect.pop_front();
               if (rsp_trust_value !== e.trust_value) begin
                  $display("%0t: trust_value expected %0d actual %0d",
                           $time, e.trust_value, rsp_trust_value);
                  errors++;
               end
               if (rsp_was_present !== e.was_present) begin
                  $display("%0t: was_present expected %0d actual %0d",
                           $time, e.was_present, rsp_was_present);
                  errors++;
               end
               if (rsp_entry_count !== e.entry_count) begin
                  $display("%0t: entry_count expected %0d actual %0d",
                           $time, e.entry_count, rsp_entry_count);
                  errors++;
               end
            end
            n_rsp++;
            stall_left = (n_rsp == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : draw_gap(n_rsp);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d requests queued, %0d responses outstanding",
                  cycle_count, pending_reqs.size(), trust_expect.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int               set_size;
      int               key;
      int unsigned      pick;
      logic [STAMP_W-1:0] tick;
      trust_req_type    r;

      // key pool: one pair shares the upper half, one the lower half
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_hi[i] = {$urandom, $urandom};
         pool_lo[i] = {$urandom, $urandom};
      end
      pool_hi[1] = pool_hi[0];
      pool_lo[2] = pool_lo[0];
      pool_hi[3] = '1;
      pool_lo[3] = '1;
      pool_hi[4] = '0;
      pool_lo[4] = '0;

      // directed: absent get and decay, blend extremes, saturation, clamp, half keys
      push_req(CMD_GET,     0, rand_q(65536), rand_q(65536), 32'd0);
      push_req(CMD_DECAY,   0, rand_q(65536), 17'd100, 32'd0);
      push_req(CMD_SUCCESS, 0, 17'd65536, rand_q(65536), 32'd0);
      push_req(CMD_SUCCESS, 0, 17'd0, rand_q(65536), 32'd1);
      push_req(CMD_FAILURE, 0, rand_q(65536), rand_q(65536), 32'd2);
      for (int i = 0; i < 4; i++)
         push_req(CMD_FAILURE, 5, rand_q(65536), rand_q(65536), 32'd3);
      push_req(CMD_DECAY,   0, rand_q(65536), 17'd0, 32'd4);
      push_req(CMD_DECAY,   0, rand_q(65536), 17'd65536, 32'd4);
      push_req(CMD_GET,     0, 17'd0, 17'd0, 32'd5);
      push_req(CMD_SUCCESS, 3, 17'h1FFFF, 17'h1FFFF, 32'hFFFF_FFFF);
      push_req(CMD_SUCCESS, 3, 17'h1FFFF, 17'h1FFFF, 32'hFFFF_FFFF);
      push_req(CMD_SUCCESS, 1, 17'd40000, rand_q(65536), 32'd6);
      push_req(CMD_SUCCESS, 2, 17'd20000, rand_q(65536), 32'd7);
      push_req(CMD_GET,     1, rand_q(65536), rand_q(65536), 32'd8);
      push_req(CMD_SUCCESS, 4, 17'd65536, 17'h1FFFF, 32'd0);
      push_req(CMD_DECAY,   4, 17'd0, 17'h1FFFF, 32'd9);
      push_req(CMD_GET,     6, rand_q(65536), rand_q(65536), 32'd9);

      // random: working sets of varying size around the table depth
      tick     = 32'd10;
      set_size = 16;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  set_size = 6;
               end
               1: begin
                  set_size = 16;
               end
               2: begin
                  set_size = 17;
               end
               default: begin
                  set_size = POOL_SIZE;
               end
            endcase
         end
         pick = $urandom_range(0, 9);
         r.cmd = (pick < 4) ? CMD_SUCCESS : (pick < 6) ? CMD_FAILURE :
                 (pick < 8) ? CMD_GET : CMD_DECAY;
         if ($urandom_range(0, 99) < 85) begin
            key  = $urandom_range(0, set_size - 1);
            r.hi = pool_hi[key];
            r.lo = pool_lo[key];
         end else begin
            r.hi = {$urandom, $urandom};
            r.lo = {$urandom, $urandom};
         end
         case ($urandom_range(0, 9))
            0: begin
               r.lq = 17'd65536;
            end
            1: begin
               r.lq = rand_q(131071);
            end
            2: begin
               r.lq = 17'd0;
            end
            default: begin
               r.lq = rand_q(65536);
            end
         endcase
         pick = $urandom_range(0, 9);
         if (pick == 0)
            r.ds = rand_q(131071);
         else if (pick == 1)
            r.ds = 17'd65536;
         else if (pick < 6)
            r.ds = rand_q(4000);
         else
            r.ds = rand_q(65536);
         // small steps make stamp ties common; an occasional wild stamp
         tick += $urandom_range(0, 2);
         r.now  = ($urandom_range(0, 19) == 0) ? $urandom : tick;
         r.gap  = draw_gap(n);
         r.sync = (n % SYNC_EVERY == 0);
         pending_reqs.push_back(r);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // drain: every request sent and every response checked
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || trust_expect.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests, %0d responses: %0d hits, %0d allocations, %0d evictions",
               n_req, n_rsp, n_hit, n_alloc, n_evict);
      $display("%0d mismatches over %0d cycles", errors, cycle_count);
      if (errors == 0 && trust_expect.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
